// ----- rtl/sparse_window_filter_response_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Sparse window filter response unit: assertion macros
// Shared property forms for the concurrent checks of the unit.
// ----------------------------------------------------------------------------
`ifndef SPARSE_WINDOW_FILTER_RESPONSE_UNIT_MACROS_SVH
`define SPARSE_WINDOW_FILTER_RESPONSE_UNIT_MACROS_SVH

// same-cycle implication
`define SWFR_ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("swfr assertion failed");

// next-cycle implication
`define SWFR_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("swfr assertion failed");

`endif

// ----- rtl/swfr_pkg.sv -----
// ----------------------------------------------------------------------------
// swfr_pkg
// Types, codes and constants shared by the sparse window filter response unit.
// ----------------------------------------------------------------------------
package swfr_pkg;

   localparam int RESP_W      = 48;
   localparam int SAMPLE_W    = 16;
   localparam int PROD_W      = 32;
   localparam int COORD_W     = 8;
   localparam int FI_FIELD_W  = 5;
   localparam int TAP_FIELD_W = 8;
   localparam int DIM_FIELD_W = 5;
   localparam int CMD_W       = 2;
   localparam int CFG_DIM_W   = 9;
   localparam int CSR_DATA_W  = 9;
   localparam int CSR_IDX_W   = 2;
   localparam int WIN_W       = 11;
   localparam int QDEPTH      = 2;

   localparam int DEF_IMAGE_DIM_MAX  = 256;
   localparam int DEF_FILTER_COUNT   = 32;
   localparam int DEF_FILTER_DIM_MAX = 16;

   localparam logic [CFG_DIM_W-1:0] CFG_DIM_RESET = 9'd256;

   localparam logic [CMD_W-1:0] CMD_PIXEL = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TAP   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SIZE  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ABSOLUTE_MODE = 2'd2;

   localparam logic signed [RESP_W-1:0] RESP_MAX = {1'b0, {(RESP_W-1){1'b1}}};
   localparam logic signed [RESP_W-1:0] RESP_MIN = {1'b1, {(RESP_W-1){1'b0}}};

   typedef enum logic [1:0] {
      OP_PIXEL = 2'd0,
      OP_TAP   = 2'd1,
      OP_SIZE  = 2'd2,
      OP_QUERY = 2'd3
   } swfr_op_type;

   typedef struct packed {
      swfr_op_type                   op;
      logic [COORD_W-1:0]            row;
      logic [COORD_W-1:0]            col;
      logic [FI_FIELD_W-1:0]         fi;
      logic [TAP_FIELD_W-1:0]        tap;
      logic signed [SAMPLE_W-1:0]    value;
      logic [DIM_FIELD_W-1:0]        fh;
      logic [DIM_FIELD_W-1:0]        fw;
      logic                          bad;
   } swfr_entry_type;

   typedef struct packed {
      logic [CFG_DIM_W-1:0] image_height;
      logic [CFG_DIM_W-1:0] image_width;
      logic                 absolute_mode;
   } swfr_cfg_type;

endpackage

// ----- rtl/swfr_front.sv -----
// ----------------------------------------------------------------------------
// swfr_front
// Accepts requests, drops out-of-range writes, and queues the rest.
// ----------------------------------------------------------------------------
module swfr_front #(
   parameter int IMAGE_DIM_MAX  = swfr_pkg::DEF_IMAGE_DIM_MAX,
   parameter int FILTER_COUNT   = swfr_pkg::DEF_FILTER_COUNT,
   parameter int FILTER_DIM_MAX = swfr_pkg::DEF_FILTER_DIM_MAX
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [swfr_pkg::CMD_W-1:0]             req_cmd,
   input  logic [swfr_pkg::COORD_W-1:0]           req_pixel_row,
   input  logic [swfr_pkg::COORD_W-1:0]           req_pixel_col,
   input  logic [swfr_pkg::FI_FIELD_W-1:0]        req_filter_index,
   input  logic [swfr_pkg::TAP_FIELD_W-1:0]       req_tap_index,
   input  logic signed [swfr_pkg::SAMPLE_W-1:0]   req_sample_value,
   input  logic [swfr_pkg::DIM_FIELD_W-1:0]       req_filter_height,
   input  logic [swfr_pkg::DIM_FIELD_W-1:0]       req_filter_width,
   output swfr_pkg::swfr_entry_type               q_entry,
   output logic                                   q_valid,
   input  logic                                   q_pop
);
   import swfr_pkg::*;

   localparam int PTR_W = $clog2(QDEPTH);
   localparam int CNT_W = $clog2(QDEPTH + 1);
   localparam int TAPS  = FILTER_DIM_MAX * FILTER_DIM_MAX;

   swfr_entry_type         q_ff [QDEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   swfr_entry_type         entry;
   logic                   keep;
   logic                   push;
   logic                   fi_ok;

   assign fi_ok = 32'(req_filter_index) < FILTER_COUNT;

   always_comb begin
      unique case (req_cmd)
         CMD_PIXEL: keep = (32'(req_pixel_row) < IMAGE_DIM_MAX) &&
                           (32'(req_pixel_col) < IMAGE_DIM_MAX);
         CMD_TAP:   keep = fi_ok && (32'(req_tap_index) < TAPS);
         CMD_SIZE:  keep = fi_ok;
         CMD_QUERY: keep = 1'b1;
         default:   keep = 1'b0;
      endcase
   end

   always_comb begin
      entry.op    = swfr_op_type'(req_cmd);
      entry.row   = req_pixel_row;
      entry.col   = req_pixel_col;
      entry.fi    = req_filter_index;
      entry.tap   = req_tap_index;
      entry.value = req_sample_value;
      entry.fh    = req_filter_height;
      entry.fw    = req_filter_width;
      entry.bad   = !fi_ok;
   end

   assign req_ready = count_ff != CNT_W'(QDEPTH);
   assign push      = req_valid && req_ready && keep;
   assign q_valid   = count_ff != '0;
   assign q_entry   = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = q_pop ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= entry;
      end
   end

   `include "sparse_window_filter_response_unit_macros.svh"

   `SWFR_ASSERT_IMPLIES(a_count_range, clock, reset, 1'b1, count_ff <= CNT_W'(QDEPTH))
   `SWFR_ASSERT_IMPLIES(a_pop_nonempty, clock, reset, q_pop, count_ff != '0)
   `SWFR_ASSERT_NEXT(a_push_grows, clock, reset, push && !q_pop, count_ff == $past(count_ff) + 1'b1)

endmodule

// ----- rtl/swfr_engine.sv -----
// ----------------------------------------------------------------------------
// swfr_engine
// Carries out queued requests: store writes and the window multiply-accumulate.
// ----------------------------------------------------------------------------
module swfr_engine #(
   parameter int IMAGE_DIM_MAX  = swfr_pkg::DEF_IMAGE_DIM_MAX,
   parameter int FILTER_COUNT   = swfr_pkg::DEF_FILTER_COUNT,
   parameter int FILTER_DIM_MAX = swfr_pkg::DEF_FILTER_DIM_MAX
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  swfr_pkg::swfr_entry_type               q_entry,
   input  logic                                   q_valid,
   output logic                                   q_pop,
   input  swfr_pkg::swfr_cfg_type                 cfg,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [swfr_pkg::RESP_W-1:0]     rsp_response,
   output logic                                   rsp_bad_query
);
   import swfr_pkg::*;

   localparam int IMG_RW = $clog2(IMAGE_DIM_MAX);
   localparam int FI_W   = (FILTER_COUNT > 1) ? $clog2(FILTER_COUNT) : 1;
   localparam int TAPS   = FILTER_DIM_MAX * FILTER_DIM_MAX;
   localparam int TAP_AW = (TAPS > 1) ? $clog2(TAPS) : 1;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_LOOKUP = 5'b00010,
      ST_WALK   = 5'b00100,
      ST_DRAIN  = 5'b01000,
      ST_DONE   = 5'b10000
   } swfr_state_type;

   logic signed [SAMPLE_W-1:0] img_mem [2**(2*IMG_RW)];
   logic signed [SAMPLE_W-1:0] tap_mem [(2**FI_W)*(2**TAP_AW)];
   logic [DIM_FIELD_W-1:0]     height_ff [FILTER_COUNT];
   logic [DIM_FIELD_W-1:0]     width_ff [FILTER_COUNT];

   swfr_state_type             state_ff, state_in;
   logic [COORD_W-1:0]         row_ff, row_in;
   logic [COORD_W-1:0]         col_ff, col_in;
   logic [FI_FIELD_W-1:0]      fi_ff, fi_in;
   logic                       bad_ff, bad_in;
   logic [DIM_FIELD_W-1:0]     h_ff, h_in;
   logic [DIM_FIELD_W-1:0]     w_ff, w_in;
   logic signed [WIN_W-1:0]    start_row_ff, start_row_in;
   logic signed [WIN_W-1:0]    cur_row_ff, cur_row_in;
   logic signed [WIN_W-1:0]    cur_col_ff, cur_col_in;
   logic [DIM_FIELD_W-1:0]     r_ff, r_in;
   logic [DIM_FIELD_W-1:0]     c_ff, c_in;
   logic [TAP_AW-1:0]          tap_off_ff, tap_off_in;
   logic [1:0]                 drain_ff, drain_in;
   logic                       s1_valid_ff, s1_valid_in;
   logic                       s2_valid_ff, s2_valid_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [RESP_W-1:0]   acc_ff, acc_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [RESP_W-1:0]   rsp_data_ff;
   logic                       rsp_bad_ff;
   logic signed [SAMPLE_W-1:0] img_rd_ff;
   logic signed [SAMPLE_W-1:0] tap_rd_ff;

   logic                       img_we, tap_we, size_we;
   logic [2*IMG_RW-1:0]        img_wr_addr, img_rd_addr;
   logic [FI_W+TAP_AW-1:0]     tap_wr_addr, tap_rd_addr;
   logic [FI_W-1:0]            fi_idx, q_fi_idx;
   logic [DIM_FIELD_W-1:0]     h_sel, w_sel, half_h, half_w;
   logic                       size_bad;
   logic [CFG_DIM_W-1:0]       eh, ew;
   logic                       inb;
   logic                       out_load;
   logic signed [RESP_W-1:0]   result;

   assign fi_idx   = FI_W'(fi_ff);
   assign q_fi_idx = FI_W'(q_entry.fi);
   assign q_pop    = (state_ff == ST_IDLE) && q_valid;
   assign img_we   = q_pop && (q_entry.op == OP_PIXEL);
   assign tap_we   = q_pop && (q_entry.op == OP_TAP);
   assign size_we  = q_pop && (q_entry.op == OP_SIZE);

   assign img_wr_addr = {IMG_RW'(q_entry.row), IMG_RW'(q_entry.col)};
   assign img_rd_addr = {IMG_RW'(cur_row_ff), IMG_RW'(cur_col_ff)};
   assign tap_wr_addr = {q_fi_idx, TAP_AW'(q_entry.tap)};
   assign tap_rd_addr = {fi_idx, tap_off_ff};

   assign eh = (32'(cfg.image_height) > IMAGE_DIM_MAX) ? CFG_DIM_W'(IMAGE_DIM_MAX)
                                                       : cfg.image_height;
   assign ew = (32'(cfg.image_width) > IMAGE_DIM_MAX) ? CFG_DIM_W'(IMAGE_DIM_MAX)
                                                      : cfg.image_width;

   assign inb = !cur_row_ff[WIN_W-1] && !cur_col_ff[WIN_W-1] &&
                (cur_row_ff < $signed({2'b00, eh})) &&
                (cur_col_ff < $signed({2'b00, ew}));

   assign h_sel    = height_ff[fi_idx];
   assign w_sel    = width_ff[fi_idx];
   assign half_h   = (h_sel - 1'b1) >> 1;
   assign half_w   = (w_sel - 1'b1) >> 1;
   assign size_bad = (h_sel == '0) || (w_sel == '0) ||
                     (32'(h_sel) > FILTER_DIM_MAX) || (32'(w_sel) > FILTER_DIM_MAX);

   assign prod_in = img_rd_ff * tap_rd_ff;

   always_ff @(posedge clock) begin
      if (img_we) begin
         img_mem[img_wr_addr] <= q_entry.value;
      end
      img_rd_ff <= img_mem[img_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (tap_we) begin
         tap_mem[tap_wr_addr] <= q_entry.value;
      end
      tap_rd_ff <= tap_mem[tap_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FILTER_COUNT; i++) begin
            height_ff[i] <= '0;
            width_ff[i]  <= '0;
         end
      end else if (size_we) begin
         height_ff[q_fi_idx] <= q_entry.fh;
         width_ff[q_fi_idx]  <= q_entry.fw;
      end
   end

   // accumulator is wide enough for any valid window, so it cannot overflow
   always_comb begin
      if (cfg.absolute_mode && acc_ff[RESP_W-1]) begin
         result = (acc_ff == RESP_MIN) ? RESP_MAX : -acc_ff;
      end else begin
         result = acc_ff;
      end
   end

   assign out_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      fi_in        = fi_ff;
      bad_in       = bad_ff;
      h_in         = h_ff;
      w_in         = w_ff;
      start_row_in = start_row_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      r_in         = r_ff;
      c_in         = c_ff;
      tap_off_in   = tap_off_ff;
      drain_in     = drain_ff;
      acc_in       = acc_ff;
      s1_valid_in  = 1'b0;
      s2_valid_in  = s1_valid_ff;
      if (s2_valid_ff) begin
         acc_in = acc_ff + {{(RESP_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (q_pop && (q_entry.op == OP_QUERY)) begin
               row_in   = q_entry.row;
               col_in   = q_entry.col;
               fi_in    = q_entry.fi;
               bad_in   = q_entry.bad;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            acc_in = '0;
            if (bad_ff || size_bad) begin
               bad_in   = 1'b1;
               state_in = ST_DONE;
            end else begin
               h_in         = h_sel;
               w_in         = w_sel;
               start_row_in = $signed({3'b000, row_ff}) - $signed({6'b000000, half_h});
               cur_row_in   = $signed({3'b000, row_ff}) - $signed({6'b000000, half_h});
               cur_col_in   = $signed({3'b000, col_ff}) - $signed({6'b000000, half_w});
               r_in         = '0;
               c_in         = '0;
               tap_off_in   = '0;
               state_in     = ST_WALK;
            end
         end
         ST_WALK: begin
            s1_valid_in = inb;
            tap_off_in  = tap_off_ff + 1'b1;
            if (r_ff == h_ff - 1'b1) begin
               r_in       = '0;
               cur_row_in = start_row_ff;
               c_in       = c_ff + 1'b1;
               cur_col_in = cur_col_ff + 1'b1;
               if (c_ff == w_ff - 1'b1) begin
                  drain_in = 2'd2;
                  state_in = ST_DRAIN;
               end
            end else begin
               r_in       = r_ff + 1'b1;
               cur_row_in = cur_row_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            drain_in = drain_ff - 1'b1;
            if (drain_ff == 2'd0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff       <= row_in;
      col_ff       <= col_in;
      fi_ff        <= fi_in;
      bad_ff       <= bad_in;
      h_ff         <= h_in;
      w_ff         <= w_in;
      start_row_ff <= start_row_in;
      cur_row_ff   <= cur_row_in;
      cur_col_ff   <= cur_col_in;
      r_ff         <= r_in;
      c_ff         <= c_in;
      tap_off_ff   <= tap_off_in;
      drain_ff     <= drain_in;
      acc_ff       <= acc_in;
      prod_ff      <= s1_valid_ff ? prod_in : '0;
      if (out_load) begin
         rsp_data_ff <= bad_ff ? '0 : result;
         rsp_bad_ff  <= bad_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_response  = rsp_data_ff;
   assign rsp_bad_query = rsp_bad_ff;

   `include "sparse_window_filter_response_unit_macros.svh"

   `SWFR_ASSERT_IMPLIES(a_walk_bounds, clock, reset, state_ff == ST_WALK, (r_ff < h_ff) && (c_ff < w_ff))
   `SWFR_ASSERT_NEXT(a_load_shows, clock, reset, out_load, rsp_valid_ff)
   `SWFR_ASSERT_IMPLIES(a_drain_empty, clock, reset, (state_ff == ST_DRAIN) && (drain_ff == 2'd0), !s1_valid_ff && !s2_valid_ff)

endmodule

// ----- rtl/sparse_window_filter_response_unit.sv -----
// ----------------------------------------------------------------------------
// sparse_window_filter_response_unit
// Image and filter bank store with window correlation at queried points.
// ----------------------------------------------------------------------------
// Requests arrive on req_* (valid/ready). Pixel, tap and size writes are
// done in the back end and give no response; out-of-range writes are dropped
// at the front. A query gives one response on rsp_* (valid/ready).
// A two-entry queue sits between front and back, so requests are taken while
// the back end is busy or a response waits.
// The single multiply-accumulate unit takes one tap per cycle over the h*w
// taps of a valid filter of h rows and w columns; a bad query skips the walk.
// The back end holds one query at a time; writes behind a stalled response
// still proceed.
// Reset clears the filter sizes and restores the csr defaults; pixel and tap
// stores are undefined until written. A stalled receiver holds the response
// register and, once the queue fills, req_ready.
// ----------------------------------------------------------------------------
module sparse_window_filter_response_unit #(
   parameter int IMAGE_DIM_MAX  = swfr_pkg::DEF_IMAGE_DIM_MAX,
   parameter int FILTER_COUNT   = swfr_pkg::DEF_FILTER_COUNT,
   parameter int FILTER_DIM_MAX = swfr_pkg::DEF_FILTER_DIM_MAX
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [swfr_pkg::CMD_W-1:0]             req_cmd,
   input  logic [swfr_pkg::COORD_W-1:0]           req_pixel_row,
   input  logic [swfr_pkg::COORD_W-1:0]           req_pixel_col,
   input  logic [swfr_pkg::FI_FIELD_W-1:0]        req_filter_index,
   input  logic [swfr_pkg::TAP_FIELD_W-1:0]       req_tap_index,
   input  logic signed [swfr_pkg::SAMPLE_W-1:0]   req_sample_value,
   input  logic [swfr_pkg::DIM_FIELD_W-1:0]       req_filter_height,
   input  logic [swfr_pkg::DIM_FIELD_W-1:0]       req_filter_width,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [swfr_pkg::RESP_W-1:0]     rsp_response,
   output logic                                   rsp_bad_query,
   input  logic                                   csr_write_enable,
   input  logic [swfr_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [swfr_pkg::CSR_DATA_W-1:0]        csr_write_data
);
   import swfr_pkg::*;

   swfr_cfg_type   cfg_ff, cfg_in;
   swfr_entry_type q_entry;
   logic           q_valid;
   logic           q_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_IMAGE_HEIGHT:  cfg_in.image_height  = csr_write_data;
            CSR_IMAGE_WIDTH:   cfg_in.image_width   = csr_write_data;
            CSR_ABSOLUTE_MODE: cfg_in.absolute_mode = csr_write_data[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_height  <= CFG_DIM_RESET;
         cfg_ff.image_width   <= CFG_DIM_RESET;
         cfg_ff.absolute_mode <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   swfr_front #(
      .IMAGE_DIM_MAX  (IMAGE_DIM_MAX),
      .FILTER_COUNT   (FILTER_COUNT),
      .FILTER_DIM_MAX (FILTER_DIM_MAX)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_pixel_row     (req_pixel_row),
      .req_pixel_col     (req_pixel_col),
      .req_filter_index  (req_filter_index),
      .req_tap_index     (req_tap_index),
      .req_sample_value  (req_sample_value),
      .req_filter_height (req_filter_height),
      .req_filter_width  (req_filter_width),
      .q_entry           (q_entry),
      .q_valid           (q_valid),
      .q_pop             (q_pop)
   );

   swfr_engine #(
      .IMAGE_DIM_MAX  (IMAGE_DIM_MAX),
      .FILTER_COUNT   (FILTER_COUNT),
      .FILTER_DIM_MAX (FILTER_DIM_MAX)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .q_entry       (q_entry),
      .q_valid       (q_valid),
      .q_pop         (q_pop),
      .cfg           (cfg_ff),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_response  (rsp_response),
      .rsp_bad_query (rsp_bad_query)
   );

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// Sparse window filter response unit testbench
// Loads pixels, taps and filter sizes, fires window queries, predicts each
// response from a local copy of the stores and compares field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import swfr_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;

   typedef struct {
      logic signed [RESP_W-1:0] response;
      logic                     bad_query;
   } response_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [CMD_W-1:0] req_cmd;
   logic [COORD_W-1:0] req_pixel_row;
   logic [COORD_W-1:0] req_pixel_col;
   logic [FI_FIELD_W-1:0] req_filter_index;
   logic [TAP_FIELD_W-1:0] req_tap_index;
   logic signed [SAMPLE_W-1:0] req_sample_value;
   logic [DIM_FIELD_W-1:0] req_filter_height;
   logic [DIM_FIELD_W-1:0] req_filter_width;
   logic rsp_valid;
   logic rsp_ready;
   logic signed [RESP_W-1:0] rsp_response;
   logic rsp_bad_query;
   logic csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   // local copy of the block state
   logic signed [SAMPLE_W-1:0] pixel_mem [65536];
   bit                         pixel_set [65536];
   logic signed [SAMPLE_W-1:0] tap_mem [8192];
   bit                         tap_set [8192];
   logic [DIM_FIELD_W-1:0]     height_tab [32];
   logic [DIM_FIELD_W-1:0]     width_tab [32];
   logic [CFG_DIM_W-1:0]       cfg_height;
   logic [CFG_DIM_W-1:0]       cfg_width;
   logic                       cfg_abs;

   response_type pending_responses[$];
   int error_count;
   int cycle_count;
   int req_idle_pct;
   int rsp_stall_pct;
   logic hold_rsp;

   sparse_window_filter_response_unit dut (.*);

   initial begin
      clock = 1'b0;
   end

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("ERROR t=%0t %s: got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // response side: random stall, checks against oldest expectation
   always @(posedge clock) begin
      response_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_responses.size() == 0) begin
            report_mismatch("unexpected response", rsp_response, 0);
         end else begin
            want = pending_responses.pop_front();
            if (rsp_response !== want.response)
               report_mismatch("response", rsp_response, want.response);
            if (rsp_bad_query !== want.bad_query)
               report_mismatch("bad_query", rsp_bad_query, want.bad_query);
         end
      end
      rsp_ready <= !hold_rsp && ($urandom_range(99) >= rsp_stall_pct);
   end

   function automatic bit filter_ok(input int fi);
      return height_tab[fi] != 0 && width_tab[fi] != 0 &&
             height_tab[fi] <= 16 && width_tab[fi] <= 16;
   endfunction

   function automatic response_type window_response(input int fi, input int row, input int col);
      response_type res;
      longint acc;
      int h, w, eh, ew, sr, sc, pr, pc;
      res.bad_query = 1'b0;
      res.response = '0;
      if (!filter_ok(fi)) begin
         res.bad_query = 1'b1;
         return res;
      end
      h = height_tab[fi];
      w = width_tab[fi];
      eh = cfg_height > 256 ? 256 : cfg_height;
      ew = cfg_width > 256 ? 256 : cfg_width;
      sr = row - (h - 1) / 2;
      sc = col - (w - 1) / 2;
      acc = 0;
      for (int c = 0; c < w; c++) begin
         pc = sc + c;
         for (int r = 0; r < h; r++) begin
            pr = sr + r;
            if (pr >= 0 && pc >= 0 && pr < eh && pc < ew)
               acc += longint'(pixel_mem[pr * 256 + pc]) *
                      longint'(tap_mem[fi * 256 + c * h + r]);
         end
      end
      if (cfg_abs && acc < 0)
         acc = -acc;
      res.response = acc[RESP_W-1:0];
      return res;
   endfunction

   function automatic void absorb_request(input swfr_op_type op, input int row, input int col,
                                          input int fi, input int tap,
                                          input logic signed [15:0] val,
                                          input int fh, input int fw);
      case (op)
         OP_PIXEL: begin
            pixel_mem[row * 256 + col] = val;
            pixel_set[row * 256 + col] = 1'b1;
         end
         OP_TAP: begin
            tap_mem[fi * 256 + tap] = val;
            tap_set[fi * 256 + tap] = 1'b1;
         end
         OP_SIZE: begin
            height_tab[fi] = DIM_FIELD_W'(fh);
            width_tab[fi] = DIM_FIELD_W'(fw);
         end
         default: pending_responses.push_back(window_response(fi, row, col));
      endcase
   endfunction

   task automatic send_request(input swfr_op_type op, input int row, input int col,
                               input int fi, input int tap, input logic signed [15:0] val,
                               input int fh, input int fw);
      if ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= op;
      req_pixel_row <= COORD_W'(row);
      req_pixel_col <= COORD_W'(col);
      req_filter_index <= FI_FIELD_W'(fi);
      req_tap_index <= TAP_FIELD_W'(tap);
      req_sample_value <= val;
      req_filter_height <= DIM_FIELD_W'(fh);
      req_filter_width <= DIM_FIELD_W'(fw);
      do @(posedge clock); while (!req_ready);
      absorb_request(op, row, col, fi, tap, val, fh, fw);
   endtask

   function automatic logic signed [15:0] rand_sample();
      case ($urandom_range(5))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // writes every pixel and tap that the query would read and that is still unset
   task automatic fill_window(input int fi, input int row, input int col);
      int h, w, eh, ew, pr, pc;
      if (!filter_ok(fi))
         return;
      h = height_tab[fi];
      w = width_tab[fi];
      eh = cfg_height > 256 ? 256 : cfg_height;
      ew = cfg_width > 256 ? 256 : cfg_width;
      for (int c = 0; c < w; c++) begin
         for (int r = 0; r < h; r++) begin
            pr = row - (h - 1) / 2 + r;
            pc = col - (w - 1) / 2 + c;
            if (pr >= 0 && pc >= 0 && pr < eh && pc < ew) begin
               if (!pixel_set[pr * 256 + pc])
                  send_request(OP_PIXEL, pr, pc, 0, 0, rand_sample(), 0, 0);
               if (!tap_set[fi * 256 + c * h + r])
                  send_request(OP_TAP, 0, 0, fi, c * h + r, rand_sample(), 0, 0);
            end
         end
      end
   endtask

   task automatic query_at(input int fi, input int row, input int col);
      fill_window(fi, row, col);
      send_request(OP_QUERY, row, col, fi, $urandom_range(255), 16'($urandom),
                   $urandom_range(31), $urandom_range(31));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_IMAGE_HEIGHT: cfg_height = CFG_DIM_W'(value);
         CSR_IMAGE_WIDTH: cfg_width = CFG_DIM_W'(value);
         default: cfg_abs = value[0];
      endcase
   endtask

   task automatic set_image(input int height, input int width, input int abs_mode);
      wait_idle();
      write_csr(CSR_IMAGE_HEIGHT, height);
      write_csr(CSR_IMAGE_WIDTH, width);
      write_csr(CSR_ABSOLUTE_MODE, abs_mode);
   endtask

   task automatic random_request();
      int fi, k, fh, fw;
      fi = $urandom_range(31);
      k = $urandom_range(99);
      if (k < 55) begin
         if ($urandom_range(3) == 0)
            query_at(fi, $urandom_range(255), $urandom_range(255));
         else
            query_at(fi, $urandom_range(12), $urandom_range(12));
      end else if (k < 70) begin
         k = $urandom_range(99);
         if (k < 3) begin
            fh = 16;
            fw = 16;
         end else if (k < 80) begin
            fh = $urandom_range(1, 6);
            fw = $urandom_range(1, 6);
         end else begin
            fh = $urandom_range(31);
            fw = $urandom_range(31);
         end
         send_request(OP_SIZE, $urandom_range(255), $urandom_range(255), fi,
                      $urandom_range(255), 16'($urandom), fh, fw);
      end else if (k < 85) begin
         send_request(OP_PIXEL, $urandom_range(255), $urandom_range(255), fi,
                      $urandom_range(255), rand_sample(), $urandom_range(31), $urandom_range(31));
      end else begin
         send_request(OP_TAP, $urandom_range(255), $urandom_range(255), fi,
                      $urandom_range(255), rand_sample(), $urandom_range(31), $urandom_range(31));
      end
   endtask

   task automatic test_directed();
      send_request(OP_SIZE, 0, 0, 0, 0, 0, 1, 1);
      send_request(OP_SIZE, 0, 0, 31, 0, 0, 2, 3);
      send_request(OP_SIZE, 0, 0, 5, 0, 0, 0, 4);
      send_request(OP_SIZE, 0, 0, 6, 0, 0, 17, 16);
      send_request(OP_SIZE, 0, 0, 7, 0, 0, 16, 31);
      send_request(OP_PIXEL, 0, 0, 0, 0, 16'sh7FFF, 0, 0);
      send_request(OP_PIXEL, 255, 255, 0, 0, 16'sh8000, 0, 0);
      send_request(OP_TAP, 0, 0, 0, 0, 16'sh8000, 0, 0);
      send_request(OP_QUERY, 0, 0, 0, 0, 0, 0, 0);
      send_request(OP_QUERY, 255, 255, 0, 0, 0, 0, 0);
      query_at(31, 0, 0);
      query_at(31, 255, 255);
      send_request(OP_QUERY, 3, 3, 5, 0, 0, 0, 0);
      send_request(OP_QUERY, 3, 3, 6, 0, 0, 0, 0);
      send_request(OP_QUERY, 3, 3, 7, 0, 0, 0, 0);
      send_request(OP_QUERY, 3, 3, 9, 0, 0, 0, 0);
   endtask

   task automatic test_config();
      set_image(1, 1, 1);
      query_at(0, 0, 0);
      query_at(31, 1, 1);
      set_image(0, 0, 0);
      query_at(31, 0, 0);
      query_at(0, 200, 17);
      set_image(511, 300, 1);
      repeat (8) random_request();
      set_image($urandom_range(1, 40), $urandom_range(1, 40), 0);
      repeat (8) random_request();
      set_image(256, 256, 0);
   endtask

   task automatic test_random_phase(input int idle_pct, input int stall_pct);
      wait_idle();
      req_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (20) random_request();
   endtask

   task automatic test_backpressure();
      wait_idle();
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      fork
         begin
            hold_rsp <= 1'b1;
            repeat (600) @(posedge clock);
            hold_rsp <= 1'b0;
         end
         begin
            for (int i = 0; i < 10; i++) query_at($urandom_range(1), i, i);
            req_valid <= 1'b0;
         end
      join
   endtask

   task automatic test_drain();
      for (int i = 0; i < 6; i++) begin
         query_at(31, $urandom_range(255), $urandom_range(255));
         wait_idle();
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = '0;
      req_pixel_row = '0;
      req_pixel_col = '0;
      req_filter_index = '0;
      req_tap_index = '0;
      req_sample_value = '0;
      req_filter_height = '0;
      req_filter_width = '0;
      rsp_ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      hold_rsp = 1'b0;
      error_count = 0;
      cycle_count = 0;
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      cfg_height = CFG_DIM_RESET;
      cfg_width = CFG_DIM_RESET;
      cfg_abs = 1'b0;
      for (int i = 0; i < 32; i++) begin
         height_tab[i] = '0;
         width_tab[i] = '0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_config();
      test_random_phase(0, 0);
      test_random_phase(57, 0);
      test_random_phase(0, 57);
      test_random_phase(30, 30);
      test_backpressure();
      test_drain();

      wait_idle();
      repeat (300) @(posedge clock);
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/swfr_pkg.sv
rtl/swfr_front.sv
rtl/swfr_engine.sv
rtl/sparse_window_filter_response_unit.sv
tb/tb.sv
